### hdl/lrutc_pkg.sv
// Shared types and constants for the LRU tile cache directory.
package lrutc_pkg;

  localparam logic [2:0] REQ_QUERY     = 3'd0;
  localparam logic [2:0] REQ_MARK      = 3'd1;
  localparam logic [2:0] REQ_CLEAN     = 3'd2;
  localparam logic [2:0] REQ_ALL_DIRTY = 3'd3;
  localparam logic [2:0] REQ_CLEAR     = 3'd4;

  localparam int TILE_W      = 24;
  localparam int FCOORD_W    = 34;
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [FCOORD_W-1:0] fcoord_t;

  typedef enum logic [2:0] {
    OP_ACK         = 3'd0,
    OP_TOUCH       = 3'd1,
    OP_TOUCH_DIRTY = 3'd2,
    OP_CLEAN       = 3'd3,
    OP_ALL_DIRTY   = 3'd4,
    OP_CLEAR       = 3'd5
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [TILE_W-1:0] x;
    logic [TILE_W-1:0] y;
    logic [3:0]        slot;
    logic              last;
  } cmd_t;

endpackage

### hdl/lrutc_fdiv.sv
// Floor division of a signed pixel coordinate by the tile size, by reciprocal multiply.
module lrutc_fdiv #(
  parameter int TILE_SIZE = 500
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic signed [31:0]       a,
  output logic                     done,
  output lrutc_pkg::fcoord_t       q
);

  localparam int L   = $clog2(TILE_SIZE);
  localparam int SH1 = (L > 0) ? 1 : 0;
  localparam int SH2 = (L > 0) ? L - 1 : 0;
  localparam longint MAGIC_L =
    ((longint'(1) << 32) * ((longint'(1) << L) - longint'(TILE_SIZE))) / longint'(TILE_SIZE)
    + longint'(1);
  localparam logic [31:0] MAGIC = 32'(MAGIC_L);

  logic        running;
  logic        phase;
  logic        fin;
  logic        neg;
  logic [31:0] mag;
  logic [31:0] t1;
  logic [31:0] quo;
  logic [32:0] mag_w;
  logic [63:0] prod;
  logic [31:0] diff;
  logic [32:0] sum;

  // negative input: floor(a/d) = -((|a| + d - 1) / d)
  always_comb begin
    mag_w = a[31] ? (33'(TILE_SIZE - 1) - {a[31], a}) : {1'b0, a};
    prod  = mag * MAGIC;
    diff  = mag - t1;
    sum   = {1'b0, t1} + {1'b0, diff >> SH1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      phase   <= 1'b0;
      fin     <= 1'b0;
    end else if (go) begin
      running <= 1'b1;
      phase   <= 1'b0;
      fin     <= 1'b0;
      neg     <= a[31];
      mag     <= mag_w[31:0];
    end else if (running) begin
      if (!phase) begin
        t1    <= prod[63:32];
        phase <= 1'b1;
      end else begin
        quo     <= 32'(sum >> SH2);
        running <= 1'b0;
        fin     <= 1'b1;
      end
    end
  end

  assign done = fin & ~running;
  assign q    = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});

endmodule

### hdl/lrutc_front.sv
// Front end: takes requests, finds the tile span and queues per-tile commands.
module lrutc_front #(
  parameter int CAPACITY  = 16,
  parameter int TILE_SIZE = 500
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             req_type,
  input  logic signed [31:0]     rect_left,
  input  logic signed [31:0]     rect_top,
  input  logic signed [31:0]     rect_right,
  input  logic signed [31:0]     rect_bottom,
  input  logic [3:0]             slot_sel,
  input  logic [$clog2(CAPACITY+1)-1:0] eff_cap,
  input  logic                   q_full,
  output logic                   q_push,
  output lrutc_pkg::cmd_t        q_data
);

  localparam int OW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_ONE  = 5'b00010,
    F_DIV  = 5'b00100,
    F_BACK = 5'b01000,
    F_EMIT = 5'b10000
  } fstate_t;

  fstate_t            state;
  lrutc_pkg::cmd_t    pend;
  lrutc_pkg::op_t     walk_op;
  lrutc_pkg::fcoord_t cur_x, cur_y;
  lrutc_pkg::fcoord_t min_x, min_y, max_x, max_y;
  logic [OW-1:0]      cnt;
  logic               accept, is_rect, empty, div_go;
  logic [3:0]         div_done;

  assign accept  = start && state == F_IDLE;
  assign is_rect = req_type == lrutc_pkg::REQ_QUERY || req_type == lrutc_pkg::REQ_MARK;
  assign empty   = rect_right < rect_left || rect_bottom < rect_top;
  assign div_go  = accept && is_rect && !empty;
  assign busy    = state != F_IDLE;

  lrutc_fdiv #(.TILE_SIZE(TILE_SIZE)) u_div_l (
    .clk(clk), .rst(rst), .go(div_go), .a(rect_left),   .done(div_done[0]), .q(min_x));
  lrutc_fdiv #(.TILE_SIZE(TILE_SIZE)) u_div_t (
    .clk(clk), .rst(rst), .go(div_go), .a(rect_top),    .done(div_done[1]), .q(min_y));
  lrutc_fdiv #(.TILE_SIZE(TILE_SIZE)) u_div_r (
    .clk(clk), .rst(rst), .go(div_go), .a(rect_right),  .done(div_done[2]), .q(max_x));
  lrutc_fdiv #(.TILE_SIZE(TILE_SIZE)) u_div_b (
    .clk(clk), .rst(rst), .go(div_go), .a(rect_bottom), .done(div_done[3]), .q(max_y));

  always_comb begin
    q_push = 1'b0;
    q_data = pend;
    if (state == F_ONE) begin
      q_push = !q_full;
    end else if (state == F_EMIT) begin
      q_push      = !q_full;
      q_data.op   = walk_op;
      q_data.x    = cur_x[lrutc_pkg::TILE_W-1:0];
      q_data.y    = cur_y[lrutc_pkg::TILE_W-1:0];
      q_data.slot = '0;
      q_data.last = cnt == OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            pend.x    <= '0;
            pend.y    <= '0;
            pend.slot <= slot_sel;
            pend.last <= 1'b1;
            walk_op   <= (req_type == lrutc_pkg::REQ_MARK) ? lrutc_pkg::OP_TOUCH_DIRTY
                                                           : lrutc_pkg::OP_TOUCH;
            if (div_go) begin
              state <= F_DIV;
            end else begin
              state <= F_ONE;
              case (req_type)
                lrutc_pkg::REQ_CLEAN:     pend.op <= lrutc_pkg::OP_CLEAN;
                lrutc_pkg::REQ_ALL_DIRTY: pend.op <= lrutc_pkg::OP_ALL_DIRTY;
                lrutc_pkg::REQ_CLEAR:     pend.op <= lrutc_pkg::OP_CLEAR;
                default:                  pend.op <= lrutc_pkg::OP_ACK;
              endcase
            end
          end
        end
        F_ONE: begin
          if (!q_full) state <= F_IDLE;
        end
        F_DIV: begin
          if (&div_done) begin
            cur_x <= max_x;
            cur_y <= max_y;
            cnt   <= OW'(1);
            state <= F_BACK;
          end
        end
        F_BACK: begin
          // step back from the last tile to the first one walked
          if (cnt >= eff_cap || (cur_x == min_x && cur_y == min_y)) begin
            state <= F_EMIT;
          end else begin
            cnt <= cnt + OW'(1);
            if (cur_y == min_y) begin
              cur_y <= max_y;
              cur_x <= cur_x - lrutc_pkg::fcoord_t'(1);
            end else begin
              cur_y <= cur_y - lrutc_pkg::fcoord_t'(1);
            end
          end
        end
        F_EMIT: begin
          if (!q_full) begin
            cnt <= cnt - OW'(1);
            if (cur_y == max_y) begin
              cur_y <= min_y;
              cur_x <= cur_x + lrutc_pkg::fcoord_t'(1);
            end else begin
              cur_y <= cur_y + lrutc_pkg::fcoord_t'(1);
            end
            if (cnt == OW'(1)) state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### hdl/lrutc_fifo.sv
// Small command queue between front and back.
module lrutc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [CW-1:0]    count;

  assign empty = count == '0;
  assign full  = count == CW'(DEPTH);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (pop && !empty) rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      count <= count + CW'(push && !full) - CW'(pop && !empty);
    end
  end

endmodule

### hdl/lrutc_back.sv
// Back end: directory lookup, LRU update, eviction and result register.
module lrutc_back #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  lrutc_pkg::cmd_t               q_data,
  output logic                          q_pop,
  input  logic [$clog2(CAPACITY+1)-1:0] eff_cap,
  output logic                          done,
  output logic                          cell_valid,
  output logic signed [23:0]            tile_x,
  output logic signed [23:0]            tile_y,
  output logic [3:0]                    slot_out,
  output logic                          was_hit,
  output logic                          dirty_out,
  output logic                          evicted,
  output logic signed [23:0]            evicted_x,
  output logic signed [23:0]            evicted_y,
  output logic                          last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_LOOK = 3'b010,
    B_EXEC = 3'b100
  } bstate_t;

  bstate_t         state;
  lrutc_pkg::cmd_t cmd;
  logic [CAPACITY-1:0] valid, dirty;
  logic [AW-1:0]   age [CAPACITY];
  logic [23:0]     tx  [CAPACITY];
  logic [23:0]     ty  [CAPACITY];
  logic [OW-1:0]   occ;

  logic [AW-1:0]   hslot, vslot, fslot, slot;
  logic            hit_c, hit, evict;
  logic            is_dirty_op, in_range;
  logic [AW-1:0]   cslot;

  assign q_pop       = state == B_IDLE && !q_empty;
  assign is_dirty_op = cmd.op == lrutc_pkg::OP_TOUCH_DIRTY;
  assign in_range    = 32'(cmd.slot) < CAPACITY;
  assign cslot       = AW'(cmd.slot);

  always_comb begin
    hit_c = 1'b0;
    hslot = '0;
    vslot = '0;
    fslot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (valid[i] && tx[i] == cmd.x && ty[i] == cmd.y) begin
        hit_c = 1'b1;
        hslot = AW'(i);
      end
      if (valid[i] && OW'(age[i]) == occ - OW'(1)) vslot = AW'(i);
      if (!valid[i]) fslot = AW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
      valid <= '0;
      dirty <= '0;
      occ   <= '0;
      for (int i = 0; i < CAPACITY; i++) age[i] <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cmd   <= q_data;
            state <= B_LOOK;
          end
        end
        B_LOOK: begin
          hit   <= hit_c;
          evict <= !hit_c && occ >= eff_cap;
          slot  <= hit_c ? hslot : ((occ >= eff_cap) ? vslot : fslot);
          state <= B_EXEC;
        end
        B_EXEC: begin
          state      <= B_IDLE;
          done       <= 1'b1;
          last       <= cmd.last;
          cell_valid <= 1'b0;
          tile_x     <= '0;
          tile_y     <= '0;
          slot_out   <= '0;
          was_hit    <= 1'b0;
          dirty_out  <= 1'b0;
          evicted    <= 1'b0;
          evicted_x  <= '0;
          evicted_y  <= '0;
          case (cmd.op)
            lrutc_pkg::OP_TOUCH, lrutc_pkg::OP_TOUCH_DIRTY: begin
              cell_valid <= 1'b1;
              tile_x     <= cmd.x;
              tile_y     <= cmd.y;
              slot_out   <= 4'(slot);
              was_hit    <= hit;
              if (hit) begin
                for (int i = 0; i < CAPACITY; i++)
                  if (valid[i] && age[i] < age[slot]) age[i] <= age[i] + AW'(1);
                age[slot] <= '0;
                if (is_dirty_op) dirty[slot] <= 1'b1;
                dirty_out <= is_dirty_op | dirty[slot];
              end else begin
                for (int i = 0; i < CAPACITY; i++)
                  if (valid[i] && AW'(i) != slot) age[i] <= age[i] + AW'(1);
                valid[slot] <= 1'b1;
                dirty[slot] <= 1'b1;
                age[slot]   <= '0;
                tx[slot]    <= cmd.x;
                ty[slot]    <= cmd.y;
                dirty_out   <= 1'b1;
                if (evict) begin
                  evicted   <= 1'b1;
                  evicted_x <= tx[slot];
                  evicted_y <= ty[slot];
                end else begin
                  occ <= occ + OW'(1);
                end
              end
            end
            lrutc_pkg::OP_CLEAN: begin
              if (in_range) begin
                dirty[cslot] <= 1'b0;
                slot_out     <= cmd.slot;
                if (valid[cslot]) begin
                  cell_valid <= 1'b1;
                  was_hit    <= 1'b1;
                  tile_x     <= tx[cslot];
                  tile_y     <= ty[cslot];
                end
              end
            end
            lrutc_pkg::OP_ALL_DIRTY: dirty <= dirty | valid;
            lrutc_pkg::OP_CLEAR: begin
              valid <= '0;
              dirty <= '0;
              occ   <= '0;
              for (int i = 0; i < CAPACITY; i++) age[i] <= '0;
            end
            default: ;
          endcase
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### hdl/lru_tile_cache_directory_top.sv
// Top level of the LRU tile cache directory.
// A request is taken when start is high and busy is low. A rectangle request
// passes through the floor dividers, then steps back tile by tile (up to
// capacity) to locate the first tile of the walk, then queues one command per
// tile; every command, tile or not, goes through the idle, lookup and execute
// states of the directory, and the next is popped only back in idle.
// Other requests, and empty rectangles, give one result. Each result is shown
// for one cycle with done high and cannot be held off; last marks the final
// result of a request. The front may take the next request while the back is
// still draining; capacity may only be written with no request in flight.
module lru_tile_cache_directory_top #(
  parameter int CAPACITY  = 16,
  parameter int TILE_SIZE = 500
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] rect_left,
  input  logic signed [31:0] rect_top,
  input  logic signed [31:0] rect_right,
  input  logic signed [31:0] rect_bottom,
  input  logic [3:0]         slot_sel,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  output logic               done,
  output logic               cell_valid,
  output logic signed [23:0] tile_x,
  output logic signed [23:0] tile_y,
  output logic [3:0]         slot_out,
  output logic               was_hit,
  output logic               dirty_out,
  output logic               evicted,
  output logic signed [23:0] evicted_x,
  output logic signed [23:0] evicted_y,
  output logic               last
);

  localparam int OW   = $clog2(CAPACITY + 1);
  localparam int CMDW = $bits(lrutc_pkg::cmd_t);

  logic [4:0]      capacity;
  logic [OW-1:0]   eff_cap;
  logic            q_push, q_pop, q_full, q_empty;
  lrutc_pkg::cmd_t push_cmd, pop_cmd;
  logic [CMDW-1:0] pop_bits;

  always_ff @(posedge clk) begin
    if (rst) capacity <= 5'd16;
    else if (cfg_we) capacity <= cfg_wdata;
  end

  always_comb begin
    if (capacity == 5'd0) eff_cap = OW'(1);
    else if (32'(capacity) > CAPACITY) eff_cap = OW'(CAPACITY);
    else eff_cap = OW'(capacity);
  end

  lrutc_front #(.CAPACITY(CAPACITY), .TILE_SIZE(TILE_SIZE)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .rect_left(rect_left), .rect_top(rect_top), .rect_right(rect_right),
    .rect_bottom(rect_bottom), .slot_sel(slot_sel), .eff_cap(eff_cap),
    .q_full(q_full), .q_push(q_push), .q_data(push_cmd));

  lrutc_fifo #(.WIDTH(CMDW), .DEPTH(lrutc_pkg::QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .wdata(push_cmd), .pop(q_pop),
    .rdata(pop_bits), .empty(q_empty), .full(q_full));

  assign pop_cmd = lrutc_pkg::cmd_t'(pop_bits);

  lrutc_back #(.CAPACITY(CAPACITY)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(pop_cmd), .q_pop(q_pop),
    .eff_cap(eff_cap), .done(done), .cell_valid(cell_valid), .tile_x(tile_x),
    .tile_y(tile_y), .slot_out(slot_out), .was_hit(was_hit), .dirty_out(dirty_out),
    .evicted(evicted), .evicted_x(evicted_x), .evicted_y(evicted_y), .last(last));

`ifndef SYNTH
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request taken but busy stayed low");
  a_evict_is_miss: assert property (@(posedge clk) disable iff (rst)
    done && evicted |-> cell_valid && !was_hit) else $error("eviction on a hit");
  a_new_is_dirty: assert property (@(posedge clk) disable iff (rst)
    done && cell_valid && !was_hit |-> dirty_out) else $error("new tile not dirty");
`endif

endmodule
